FILE: src/fraction_add_reduce_defines.svh
// Assertion macros for the fraction adder.
`ifndef FRACTION_ADD_REDUCE_DEFINES_SVH
`define FRACTION_ADD_REDUCE_DEFINES_SVH
`ifndef SYNTHESIS
`define FAR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FAR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FAR_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define FAR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/far_pkg.sv
// Types, constants and command structs for the fraction adder.
`default_nettype none
package far_pkg;
  localparam int OPERAND_BITS = 31;
  localparam int WIDE_BITS = 63;
  localparam int CNT_BITS = 6;

  typedef struct packed {
    logic [OPERAND_BITS-1:0] num_first;
    logic [OPERAND_BITS-1:0] den_first;
    logic [OPERAND_BITS-1:0] num_second;
    logic [OPERAND_BITS-1:0] den_second;
  } in_item_t;

  typedef struct packed {
    logic [62:0] sum_num;
    logic [61:0] sum_den;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GCD1, ST_DIV1, ST_GCD2, ST_DIV2, ST_MUL,
    ST_GCD3, ST_DIV3, ST_OUT
  } state_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_GCD_STEP, OP_DIV_START, OP_DIV_STEP,
    OP_SAVE1, OP_SAVE2, OP_MUL, OP_SAVE3
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
  } status_t;
endpackage
`default_nettype wire

FILE: src/far_datapath.sv
// Datapath: binary gcd and restoring division units, operand registers.
`default_nettype none
module far_datapath (
  input  wire logic              clk,
  input  wire far_pkg::in_item_t in_item,
  input  wire far_pkg::cmd_t     cmd,
  output far_pkg::status_t       status,
  output far_pkg::out_item_t     out_item
);
  localparam int W = far_pkg::WIDE_BITS;
  localparam int OB = far_pkg::OPERAND_BITS;

  logic [W-1:0] a, b, c, d;
  logic [W-1:0] gu, gv;
  logic [far_pkg::CNT_BITS-1:0] gk;
  logic [W-1:0] g;
  logic [W-1:0] dq0, dq1, dr0, dr1;
  logic [far_pkg::CNT_BITS-1:0] dcnt;
  logic [W:0] rt0, rt1;
  logic [W-1:0] gmin, gmax;
  logic [2*OB-1:0] p_ad, p_cb, p_bd;
  logic [W-1:0] cross_sum, den_prod;

  assign p_ad = (2*OB)'(a[OB-1:0]) * (2*OB)'(d[OB-1:0]);
  assign p_cb = (2*OB)'(c[OB-1:0]) * (2*OB)'(b[OB-1:0]);
  assign p_bd = (2*OB)'(b[OB-1:0]) * (2*OB)'(d[OB-1:0]);
  assign cross_sum = W'(p_ad) + W'(p_cb);
  assign den_prod = W'(p_bd);

  assign rt0 = {dr0, dq0[W-1]} - {1'b0, g};
  assign rt1 = {dr1, dq1[W-1]} - {1'b0, g};
  assign gmin = (gu < gv) ? gu : gv;
  assign gmax = (gu < gv) ? gv : gu;

  always_comb begin
    status.gcd_done = (gu == '0) || (gv == '0);
    status.div_done = (dcnt == '0);
  end

  // Operands rotate so every divide works on c and d.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      far_pkg::OP_LOAD: begin
        c <= W'(in_item.num_first);
        d <= W'(in_item.den_first);
        a <= W'(in_item.num_second);
        b <= W'(in_item.den_second);
        gu <= W'(in_item.num_first);
        gv <= W'(in_item.den_first);
        gk <= '0;
      end
      far_pkg::OP_GCD_STEP: begin
        if (!gu[0] && !gv[0]) begin
          gu <= gu >> 1;
          gv <= gv >> 1;
          gk <= gk + far_pkg::CNT_BITS'(1);
        end else if (!gu[0]) begin
          gu <= gu >> 1;
        end else if (!gv[0]) begin
          gv <= gv >> 1;
        end else begin
          gu <= gmin;
          gv <= gmax - gmin;
        end
      end
      far_pkg::OP_DIV_START: begin
        g <= ((gu | gv) == '0) ? W'(1) : ((gu | gv) << gk);
        dq0 <= c;
        dq1 <= d;
        dr0 <= '0;
        dr1 <= '0;
        dcnt <= far_pkg::CNT_BITS'(W);
      end
      far_pkg::OP_DIV_STEP: begin
        if (!rt0[W]) begin
          dr0 <= rt0[W-1:0];
          dq0 <= {dq0[W-2:0], 1'b1};
        end else begin
          dr0 <= {dr0[W-2:0], dq0[W-1]};
          dq0 <= {dq0[W-2:0], 1'b0};
        end
        if (!rt1[W]) begin
          dr1 <= rt1[W-1:0];
          dq1 <= {dq1[W-2:0], 1'b1};
        end else begin
          dr1 <= {dr1[W-2:0], dq1[W-1]};
          dq1 <= {dq1[W-2:0], 1'b0};
        end
        dcnt <= dcnt - far_pkg::CNT_BITS'(1);
      end
      far_pkg::OP_SAVE1: begin
        a <= dq0;
        b <= dq1;
        c <= a;
        d <= b;
        gu <= a;
        gv <= b;
        gk <= '0;
      end
      far_pkg::OP_SAVE2: begin
        c <= dq0;
        d <= dq1;
      end
      far_pkg::OP_MUL: begin
        c <= cross_sum;
        d <= den_prod;
        gu <= cross_sum;
        gv <= den_prod;
        gk <= '0;
      end
      far_pkg::OP_SAVE3: begin
        out_item.sum_num <= (c == '0) ? '0 : dq0;
        out_item.sum_den <= (c == '0) ? 62'd1 : dq1[61:0];
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: src/far_controller.sv
// Controller state machine sequencing the gcd, divide and multiply steps.
`default_nettype none
module far_controller (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             out_stall,
  input  wire far_pkg::status_t status,
  output far_pkg::cmd_t         cmd,
  output logic                  in_stall,
  output logic                  out_valid
);
  far_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= far_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op = far_pkg::OP_NONE;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      far_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = far_pkg::OP_LOAD;
          state_next = far_pkg::ST_GCD1;
        end
      end
      far_pkg::ST_GCD1, far_pkg::ST_GCD2, far_pkg::ST_GCD3: begin
        if (status.gcd_done) begin
          cmd.op = far_pkg::OP_DIV_START;
          state_next = (state == far_pkg::ST_GCD1) ? far_pkg::ST_DIV1 :
                       (state == far_pkg::ST_GCD2) ? far_pkg::ST_DIV2 :
                       far_pkg::ST_DIV3;
        end else begin
          cmd.op = far_pkg::OP_GCD_STEP;
        end
      end
      far_pkg::ST_DIV1, far_pkg::ST_DIV2, far_pkg::ST_DIV3: begin
        if (status.div_done) begin
          priority case (state)
            far_pkg::ST_DIV1: begin
              cmd.op = far_pkg::OP_SAVE1;
              state_next = far_pkg::ST_GCD2;
            end
            far_pkg::ST_DIV2: begin
              cmd.op = far_pkg::OP_SAVE2;
              state_next = far_pkg::ST_MUL;
            end
            default: begin
              cmd.op = far_pkg::OP_SAVE3;
              state_next = far_pkg::ST_OUT;
            end
          endcase
        end else begin
          cmd.op = far_pkg::OP_DIV_STEP;
        end
      end
      far_pkg::ST_MUL: begin
        cmd.op = far_pkg::OP_MUL;
        state_next = far_pkg::ST_GCD3;
      end
      far_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = far_pkg::ST_IDLE;
      end
      default: state_next = far_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: src/fraction_add_reduce.sv
// Top level of the fraction adder with reduction to lowest terms.
// Adds two fractions and returns the sum in lowest terms, one transaction at a
// time. The time from acceptance to out_valid is data dependent: three binary gcd
// runs (one shift or subtract per cycle, on 31-bit pairs for the operands and
// up to 63 bits for the sum), each followed by a restoring divide of both values
// in parallel. The next transaction can be taken in the cycle after the result is
// taken.
`default_nettype none
`include "fraction_add_reduce_defines.svh"
module fraction_add_reduce (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire far_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output far_pkg::out_item_t      out_data
);
  far_pkg::cmd_t    cmd;
  far_pkg::status_t status;

  far_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd), .in_stall(in_stall), .out_valid(out_valid)
  );

  far_datapath u_dp (
    .clk(clk), .in_item(in_data), .cmd(cmd), .status(status), .out_item(out_data)
  );

  `FAR_ASSERT_IMPL(a_excl, clk, rst, out_valid, in_stall)
  `FAR_ASSERT_NEXT(a_accept, clk, rst, in_valid && !in_stall, in_stall && !out_valid)
  `FAR_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
endmodule
`default_nettype wire
